// ===== hw/rtl/ira_pkg.sv =====
package ira_pkg;

  // table geometry
  localparam int MAX_EXTENTS   = 64;
  localparam int IDX_W         = $clog2(MAX_EXTENTS);
  localparam int CNT_W         = $clog2(MAX_EXTENTS + 1);
  localparam int ID_W          = 32;
  localparam int ST_W          = 2;
  localparam int FREE_INTERVAL = 10000;
  localparam int FC_W          = 14;

  // result status codes
  localparam logic [ST_W-1:0] STAT_OK   = 2'd0;
  localparam logic [ST_W-1:0] STAT_FAIL = 2'd1;
  localparam logic [ST_W-1:0] STAT_DROP = 2'd2;

  // input kind codes
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FF_START,
    OP_FF_STEP,
    OP_FF_TAKE,
    OP_SHIFT,
    OP_SHIFT_DONE,
    OP_FREE_PUSH,
    OP_C_INIT,
    OP_C_SKIP,
    OP_C_READ,
    OP_C_HEAD,
    OP_C_SCAN,
    OP_C_EMIT,
    OP_C_PASS,
    OP_RES_ALLOC,
    OP_RES_FREE,
    OP_RES_DROP
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic take_empty;
    logic got_zero;
    logic cur_end;
    logic cur_used;
    logic merged;
    logic full;
    logic fc_wrap;
    logic is_free;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FF_START,
    S_FF_SCAN,
    S_SHIFT,
    S_FF_CHECK,
    S_FREE_CHK,
    S_PUSH,
    S_C_INIT,
    S_C_PICK,
    S_C_HEAD,
    S_C_SCAN,
    S_RES_ALLOC,
    S_RES_FREE,
    S_RES_DROP
  } state_t;

  typedef enum logic [1:0] {
    RET_ALLOC,
    RET_FULL,
    RET_FREE
  } ret_t;

  // logical table position to physical slot of a circular bank
  function automatic logic [IDX_W-1:0] log2phys(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] k);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, k};
    if (sum >= (CNT_W + 1)'(MAX_EXTENTS)) begin
      sum = sum - (CNT_W + 1)'(MAX_EXTENTS);
    end
    return sum[IDX_W-1:0];
  endfunction

  // circular decrement of a slot index
  function automatic logic [IDX_W-1:0] wrap_dec(logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) begin
      r = IDX_W'(MAX_EXTENTS - 1);
    end else begin
      r = v - IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ira_dp.sv =====
module ira_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ira_pkg::dp_cmd_t             cmd,
  output ira_pkg::dp_stat_t            stat,
  input  logic                         in_kind,
  input  logic [ira_pkg::ID_W-1:0]     in_start,
  input  logic [ira_pkg::ID_W-1:0]     in_count,
  input  logic                         cfg_we,
  input  logic [ira_pkg::ID_W-1:0]     cfg_wdata,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic [ira_pkg::ID_W-1:0]     out_id,
  output logic [ira_pkg::ST_W-1:0]     out_status
);
  import ira_pkg::*;

  // two banks of extents, {length, start} per entry
  logic [2*ID_W-1:0] mem [2*MAX_EXTENTS];
  logic [2*ID_W-1:0] rdata_r;

  logic                  bank_r, bank_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [FC_W-1:0]       fc_r, fc_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [CNT_W-1:0]      cur_r, cur_nxt;
  logic [MAX_EXTENTS-1:0] used_r, used_nxt;
  logic [ID_W-1:0]       s_r, s_nxt, l_r, l_nxt;
  logic [CNT_W-1:0]      made_r, made_nxt;
  logic [IDX_W-1:0]      newhead_r, newhead_nxt;
  logic                  merged_r, merged_nxt;
  logic                  kind_r, kind_nxt;
  logic [ID_W-1:0]       sin_r, sin_nxt, want_r, want_nxt, got_r, got_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [ST_W-1:0]       out_st_r, out_st_nxt;

  logic [ID_W-1:0]       rstart, rlen;
  logic [CNT_W-1:0]      rd_k;
  logic                  mem_we;
  logic                  wr_bank;
  logic [IDX_W-1:0]      wr_idx;
  logic [2*ID_W-1:0]     wdata;

  assign rstart = rdata_r[ID_W-1:0];
  assign rlen   = rdata_r[2*ID_W-1:ID_W];

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{wr_bank, wr_idx}] <= wdata;
    end
    rdata_r <= mem[{bank_r, log2phys(head_r, rd_k)}];
  end

  // operation decode
  always_comb begin
    bank_nxt      = bank_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    fc_nxt        = fc_r;
    j_nxt         = j_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    s_nxt         = s_r;
    l_nxt         = l_r;
    made_nxt      = made_r;
    newhead_nxt   = newhead_r;
    merged_nxt    = merged_r;
    kind_nxt      = kind_r;
    sin_nxt       = sin_r;
    want_nxt      = want_r;
    got_nxt       = got_r;
    out_valid_nxt = out_valid_r;
    out_id_nxt    = out_id_r;
    out_st_nxt    = out_st_r;
    rd_k          = '0;
    mem_we        = 1'b0;
    wr_bank       = bank_r;
    wr_idx        = '0;
    wdata         = '0;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        kind_nxt = in_kind;
        sin_nxt  = in_start;
        want_nxt = in_count;
      end
      OP_FF_START: begin
        got_nxt = '0;
        j_nxt   = '0;
      end
      OP_FF_STEP: begin
        rd_k  = j_r + CNT_W'(1);
        j_nxt = j_r + CNT_W'(1);
      end
      OP_FF_TAKE: begin
        got_nxt = rstart;
        if (rlen == want_r) begin
          rd_k  = j_r + CNT_W'(1);
          j_nxt = j_r + CNT_W'(1);
        end else begin
          mem_we = 1'b1;
          wr_idx = log2phys(head_r, j_r);
          wdata  = {rlen - want_r, rstart + want_r};
        end
      end
      OP_SHIFT: begin
        mem_we = 1'b1;
        wr_idx = log2phys(head_r, j_r - CNT_W'(1));
        wdata  = rdata_r;
        rd_k   = j_r + CNT_W'(1);
        j_nxt  = j_r + CNT_W'(1);
      end
      OP_SHIFT_DONE: begin
        count_nxt = count_r - CNT_W'(1);
      end
      OP_FREE_PUSH: begin
        head_nxt  = wrap_dec(head_r);
        mem_we    = 1'b1;
        wr_idx    = wrap_dec(head_r);
        wdata     = {want_r, sin_r};
        count_nxt = count_r + CNT_W'(1);
        if (fc_r == FC_W'(FREE_INTERVAL - 1)) begin
          fc_nxt = '0;
        end else begin
          fc_nxt = fc_r + FC_W'(1);
        end
      end
      OP_C_INIT: begin
        used_nxt    = '0;
        cur_nxt     = '0;
        made_nxt    = '0;
        newhead_nxt = '0;
        merged_nxt  = 1'b0;
      end
      OP_C_SKIP: begin
        cur_nxt = cur_r + CNT_W'(1);
      end
      OP_C_READ: begin
        rd_k = cur_r;
      end
      OP_C_HEAD: begin
        s_nxt = rstart;
        l_nxt = rlen;
        rd_k  = cur_r + CNT_W'(1);
        j_nxt = cur_r + CNT_W'(1);
      end
      OP_C_SCAN: begin
        // absorb a neighbor that touches either end of the current extent
        if (!used_r[j_r[IDX_W-1:0]]) begin
          if (s_r + l_r == rstart) begin
            l_nxt                     = l_r + rlen;
            used_nxt[j_r[IDX_W-1:0]]  = 1'b1;
            merged_nxt                = 1'b1;
          end else if (s_r == rstart + rlen) begin
            s_nxt                     = rstart;
            l_nxt                     = l_r + rlen;
            used_nxt[j_r[IDX_W-1:0]]  = 1'b1;
            merged_nxt                = 1'b1;
          end
        end
        rd_k  = j_r + CNT_W'(1);
        j_nxt = j_r + CNT_W'(1);
      end
      OP_C_EMIT: begin
        newhead_nxt = wrap_dec(newhead_r);
        mem_we      = 1'b1;
        wr_bank     = ~bank_r;
        wr_idx      = wrap_dec(newhead_r);
        wdata       = {l_r, s_r};
        made_nxt    = made_r + CNT_W'(1);
        cur_nxt     = cur_r + CNT_W'(1);
      end
      OP_C_PASS: begin
        bank_nxt  = ~bank_r;
        head_nxt  = newhead_r;
        count_nxt = made_r;
      end
      OP_RES_ALLOC: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = got_r;
        out_st_nxt    = (got_r == '0) ? STAT_FAIL : STAT_OK;
      end
      OP_RES_FREE: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_st_nxt    = STAT_OK;
      end
      OP_RES_DROP: begin
        out_valid_nxt = 1'b1;
        out_id_nxt    = '0;
        out_st_nxt    = STAT_DROP;
      end
      default: begin
      end
    endcase
    // capacity write reloads the table with one extent at id one, or empties it for zero capacity
    if (cfg_we) begin
      count_nxt = (cfg_wdata != '0) ? CNT_W'(1) : '0;
      fc_nxt    = '0;
      mem_we    = 1'b1;
      wr_bank   = bank_r;
      wr_idx    = head_r;
      wdata     = {cfg_wdata, ID_W'(1)};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bank_r      <= bank_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    j_r       <= j_nxt;
    cur_r     <= cur_nxt;
    used_r    <= used_nxt;
    s_r       <= s_nxt;
    l_r       <= l_nxt;
    made_r    <= made_nxt;
    newhead_r <= newhead_nxt;
    merged_r  <= merged_nxt;
    kind_r    <= kind_nxt;
    sin_r     <= sin_nxt;
    want_r    <= want_nxt;
    got_r     <= got_nxt;
    out_id_r  <= out_id_nxt;
    out_st_r  <= out_st_nxt;
  end

  // status to the controller
  always_comb begin
    stat.scan_end   = (j_r >= count_r);
    stat.hit        = (want_r <= rlen);
    stat.take_empty = (rlen == want_r);
    stat.got_zero   = (got_r == '0);
    stat.cur_end    = (cur_r >= count_r);
    stat.cur_used   = used_r[cur_r[IDX_W-1:0]];
    stat.merged     = merged_r;
    stat.full       = (count_r >= CNT_W'(MAX_EXTENTS));
    stat.fc_wrap    = (fc_r == FC_W'(FREE_INTERVAL - 1));
    stat.is_free    = (kind_r == KIND_FREE);
    stat.out_free   = !out_valid_r || out_tready;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_status = out_st_r;

endmodule

// ===== hw/rtl/ira_ctrl.sv =====
module ira_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ira_pkg::dp_stat_t  stat,
  output ira_pkg::dp_cmd_t   cmd
);
  import ira_pkg::*;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   retry_r, retry_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RET_ALLOC;
      retry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      retry_r <= retry_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    retry_nxt = retry_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_free) begin
          retry_nxt = 1'b0;
          state_nxt = S_FF_START;
        end else if (stat.full) begin
          ret_nxt   = RET_FULL;
          state_nxt = S_C_INIT;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_FF_START: begin
        cmd.op    = OP_FF_START;
        state_nxt = S_FF_SCAN;
      end
      S_FF_SCAN: begin
        if (stat.scan_end) begin
          if (retry_r) begin
            state_nxt = S_RES_ALLOC;
          end else begin
            retry_nxt = 1'b1;
            ret_nxt   = RET_ALLOC;
            state_nxt = S_C_INIT;
          end
        end else if (stat.hit) begin
          cmd.op    = OP_FF_TAKE;
          state_nxt = stat.take_empty ? S_SHIFT : S_FF_CHECK;
        end else begin
          cmd.op = OP_FF_STEP;
        end
      end
      S_SHIFT: begin
        if (stat.scan_end) begin
          cmd.op    = OP_SHIFT_DONE;
          state_nxt = S_FF_CHECK;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_FF_CHECK: begin
        // an id of zero counts as a miss and earns one retry
        if (stat.got_zero && !retry_r) begin
          retry_nxt = 1'b1;
          ret_nxt   = RET_ALLOC;
          state_nxt = S_C_INIT;
        end else begin
          state_nxt = S_RES_ALLOC;
        end
      end
      S_FREE_CHK: begin
        state_nxt = stat.full ? S_RES_DROP : S_PUSH;
      end
      S_PUSH: begin
        cmd.op = OP_FREE_PUSH;
        if (stat.fc_wrap) begin
          ret_nxt   = RET_FREE;
          state_nxt = S_C_INIT;
        end else begin
          state_nxt = S_RES_FREE;
        end
      end
      S_C_INIT: begin
        cmd.op    = OP_C_INIT;
        state_nxt = S_C_PICK;
      end
      S_C_PICK: begin
        if (stat.cur_end) begin
          cmd.op = OP_C_PASS;
          if (stat.merged) begin
            state_nxt = S_C_INIT;
          end else begin
            unique case (ret_r)
              RET_ALLOC: state_nxt = S_FF_START;
              RET_FULL:  state_nxt = S_FREE_CHK;
              RET_FREE:  state_nxt = S_RES_FREE;
              default:   state_nxt = S_RES_FREE;
            endcase
          end
        end else if (stat.cur_used) begin
          cmd.op = OP_C_SKIP;
        end else begin
          cmd.op    = OP_C_READ;
          state_nxt = S_C_HEAD;
        end
      end
      S_C_HEAD: begin
        cmd.op    = OP_C_HEAD;
        state_nxt = S_C_SCAN;
      end
      S_C_SCAN: begin
        if (stat.scan_end) begin
          cmd.op    = OP_C_EMIT;
          state_nxt = S_C_PICK;
        end else begin
          cmd.op = OP_C_SCAN;
        end
      end
      S_RES_ALLOC: begin
        if (stat.out_free) begin
          cmd.op    = OP_RES_ALLOC;
          state_nxt = S_IDLE;
        end
      end
      S_RES_FREE: begin
        if (stat.out_free) begin
          cmd.op    = OP_RES_FREE;
          state_nxt = S_IDLE;
        end
      end
      S_RES_DROP: begin
        if (stat.out_free) begin
          cmd.op    = OP_RES_DROP;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/id_range_allocator_unit.sv =====
// channel | dir | handshake             | payload
// in      | in  | in_tvalid/in_tready   | tuser: kind; tdata: start_id, count
// out     | out | out_tvalid/out_tready | tdata: first_id, status
// cfg     | in  | cfg_we                | cfg_wdata: initial_capacity
//
// one item at a time; an allocate scans the table in order for the first
// extent that fits, and when that extent is used up it moves every later
// entry down one position; the extent memory, read one entry a cycle,
// sets the scan pace. each coalescing pass compares every unused extent
// with each later entry that is not yet merged.
// reset empties the table at once; no clearing pass is needed.
// a waiting result does not block the next beat: the block stalls only at
// the point it must hand over a new result while the old one is unread.
module id_range_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // kind
  input  logic [63:0] in_tdata,   // start_id[31:0], count[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // first_id[31:0], status[33:32], zero pad
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import ira_pkg::*;

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic [ID_W-1:0] out_id;
  logic [ST_W-1:0] out_status;

  // sequencer
  ira_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // extent table and arithmetic
  ira_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (in_tuser),
    .in_start   (in_tdata[31:0]),
    .in_count   (in_tdata[63:32]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_id     (out_id),
    .out_status (out_status)
  );

  assign out_tdata = {6'b0, out_status, out_id};

`ifndef SYNTH
  // an accepted beat keeps the input closed on the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // never push into a full table
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_FREE_PUSH |-> !stat.full)
    else $error("extent table overflow");

  // a new result only comes from a result command
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(cmd.op) == OP_RES_ALLOC ||
                           $past(cmd.op) == OP_RES_FREE ||
                           $past(cmd.op) == OP_RES_DROP))
    else $error("result raised without a result command");
`endif

endmodule

// ===== tb/id_range_allocator_unit_test.sv =====
module id_range_allocator_unit_test;
  import ira_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int LONG_HOLD      = 3000;

  typedef struct {
    logic [31:0] first;
    logic [31:0] len;
  } extent_t;

  // one request beat; recycle picks a live allocation to free at drive time
  typedef struct {
    logic        kind;
    logic [31:0] start_id;
    logic [31:0] count;
    bit          recycle;
  } request_t;

  typedef struct {
    logic [31:0]     first_id;
    logic [ST_W-1:0] status;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // shadow allocator state
  extent_t     free_table[$];
  extent_t     live_runs[$];
  logic [31:0] capacity;
  int          frees_since;

  request_t    pending_requests[$];
  grant_t      expected_grants[$];
  int          fail_count;
  int          tx_gap;
  int          rx_wait;
  int          grants_seen;
  int          idle_cycles;
  bit          tx_burst;
  bit          rx_burst;

  id_range_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // table holds one extent starting at one, or nothing for zero capacity
  function automatic void load_table();
    extent_t e;
    frees_since = 0;
    free_table.delete();
    if (capacity != 0) begin
      e.first = 32'd1;
      e.len   = capacity;
      free_table.push_back(e);
    end
  endfunction

  // merge passes until stable; each pass reverses table order
  function automatic void merge_table();
    bit      merged;
    extent_t work[$];
    extent_t built[$];
    extent_t head;
    int      i;
    merged = 1'b1;
    while (merged) begin
      merged = 1'b0;
      work = free_table;
      built.delete();
      while (work.size() > 0) begin
        head = work[0];
        work.delete(0);
        i = 0;
        while (i < work.size()) begin
          if (head.first + head.len == work[i].first) begin
            head.len += work[i].len;
            work.delete(i);
            merged = 1'b1;
          end else if (head.first == work[i].first + work[i].len) begin
            head.first = work[i].first;
            head.len += work[i].len;
            work.delete(i);
            merged = 1'b1;
          end else begin
            i++;
          end
        end
        built.insert(0, head);
      end
      free_table = built;
    end
  endfunction

  function automatic logic [31:0] take_first_fit(logic [31:0] want);
    logic [31:0] got;
    for (int i = 0; i < free_table.size(); i++) begin
      if (want <= free_table[i].len) begin
        got = free_table[i].first;
        free_table[i].len   -= want;
        free_table[i].first += want;
        if (free_table[i].len == 0) free_table.delete(i);
        return got;
      end
    end
    return 32'd0;
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t  g;
    extent_t e;
    extent_t run;
    g.first_id = '0;
    g.status   = STAT_OK;
    if (r.kind == KIND_ALLOC) begin
      g.first_id = take_first_fit(r.count);
      if (g.first_id == 0) begin
        merge_table();
        g.first_id = take_first_fit(r.count);
      end
      if (g.first_id == 0) begin
        g.status = STAT_FAIL;
      end else if (r.count != 0) begin
        run.first = g.first_id;
        run.len   = r.count;
        live_runs.push_back(run);
      end
    end else begin
      if (free_table.size() >= MAX_EXTENTS) merge_table();
      if (free_table.size() >= MAX_EXTENTS) begin
        g.status = STAT_DROP;
      end else begin
        e.first = r.start_id;
        e.len   = r.count;
        free_table.insert(0, e);
        frees_since++;
        if (frees_since >= FREE_INTERVAL) begin
          frees_since = 0;
          merge_table();
        end
      end
    end
    return g;
  endfunction

  // driver: predicts on each accepted beat, then loads the next one
  always @(posedge clk) begin
    request_t r;
    int       k;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'b0;
      in_tdata  <= '0;
      tx_gap    = 0;
      tx_burst  = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        r.kind     = in_tuser;
        r.start_id = in_tdata[31:0];
        r.count    = in_tdata[63:32];
        r.recycle  = 1'b0;
        expected_grants.push_back(predict_grant(r));
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          r = pending_requests[0];
          pending_requests.delete(0);
          if (r.recycle && live_runs.size() > 0) begin
            k = $urandom_range(0, live_runs.size() - 1);
            r.start_id = live_runs[k].first;
            r.count    = live_runs[k].len;
            live_runs.delete(k);
          end
          in_tvalid <= 1'b1;
          in_tuser  <= r.kind;
          in_tdata  <= {r.count, r.start_id};
          if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat against the oldest expected grant
  always @(posedge clk) begin
    grant_t g;
    if (!rst_n) begin
      out_tready  <= 1'b0;
      rx_wait     = 0;
      rx_burst    = 1'b0;
      grants_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        grants_seen++;
        if (expected_grants.size() == 0) begin
          $error("unexpected result beat first_id %h status %0d",
                 out_tdata[31:0], out_tdata[33:32]);
          fail_count++;
        end else begin
          g = expected_grants[0];
          expected_grants.delete(0);
          if (out_tdata[31:0] !== g.first_id) begin
            $error("first_id expected %h actual %h", g.first_id, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[33:32] !== g.status) begin
            $error("status expected %0d actual %0d", g.status, out_tdata[33:32]);
            fail_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        if (grants_seen == 400) rx_wait = LONG_HOLD;
        else rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(logic kind, logic [31:0] start_id, logic [31:0] count,
                               bit recycle);
    request_t r;
    r.kind     = kind;
    r.start_id = start_id;
    r.count    = count;
    r.recycle  = recycle;
    pending_requests.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_tvalid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity = value;
    load_table();
    live_runs.delete();
  endtask

  // mostly alloc and free of live runs, some scattered noise frees
  task automatic queue_mix(int n, int max_count);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 19) == 0) queue_request(KIND_ALLOC, $urandom, $urandom, 0);
        else queue_request(KIND_ALLOC, $urandom, $urandom_range(0, max_count), 0);
      end else if (pick < 90) begin
        queue_request(KIND_FREE, 32'd0, 32'd0, 1);
      end else if (pick < 95) begin
        queue_request(KIND_FREE, $urandom, $urandom, 0);
      end else begin
        queue_request(KIND_FREE, $urandom_range(0, 4000), $urandom_range(0, 8), 0);
      end
    end
  endtask

  initial begin
    logic [31:0] caps[6];
    fail_count = 0;
    capacity   = '0;
    load_table();
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table after reset
    queue_request(KIND_ALLOC, 32'd0, 32'd1, 0);
    queue_request(KIND_FREE, 32'd50, 32'd3, 0);
    wait_drained();

    // directed corners
    set_capacity(32'd16);
    queue_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd16, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd1, 0);
    queue_request(KIND_FREE, 32'd0, 32'd5, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd5, 0);
    queue_request(KIND_FREE, 32'd9, 32'd0, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd0, 0);
    queue_request(KIND_FREE, 32'hFFFF_FFFF, 32'd2, 0);
    queue_request(KIND_FREE, 32'd1, 32'd4, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd6, 0);
    queue_request(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF, 0);
    queue_request(KIND_FREE, 32'd0, 32'd0, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd0, 0);
    wait_drained();

    // fill the table with gapped runs so frees get dropped
    set_capacity(32'd1);
    for (int i = 0; i < 80; i++) queue_request(KIND_FREE, 32'd10 + 32'(i) * 3, 32'd1, 0);
    queue_request(KIND_ALLOC, 32'd0, 32'd2, 0);
    queue_mix(40, 4);
    wait_drained();

    caps[0] = 32'd0;
    caps[1] = 32'hFFFF_FFFF;
    caps[2] = 32'd100;
    caps[3] = 32'd5000;
    caps[4] = $urandom;
    caps[5] = $urandom_range(1, 400);
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      queue_mix(310, (p % 2) ? 64 : 16);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
